### design/assert_macros.svh
// Shared assertion macros. Both expect clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SBLS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, held off during reset.
`define SBLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/sbls_pkg.sv
`default_nettype none
package sbls_pkg;

  // Store geometry
  localparam int MaxVars      = 256;
  localparam int MaxClauseLen = 16;
  localparam int WeightW      = 26;
  localparam int SumW         = WeightW + 1;
  localparam int LitW         = 10;
  localparam int VarW         = $clog2(MaxVars + 1);
  localparam int AddrW        = $clog2(MaxVars);
  localparam int FillW        = $clog2(MaxClauseLen + 1);
  localparam int BufAW        = $clog2(MaxClauseLen);

  // Stream widths
  localparam int InDataW  = 24;
  localparam int OutDataW = 16;

  // Operation codes carried on in_tuser
  localparam logic [1:0] FuncClear  = 2'd0;
  localparam logic [1:0] FuncLit    = 2'd1;
  localparam logic [1:0] FuncAssign = 2'd2;
  localparam logic [1:0] FuncSelect = 2'd3;

  // One store entry per variable
  typedef struct packed {
    logic               asg;
    logic [WeightW-1:0] pos;
    logic [WeightW-1:0] neg;
  } sbls_word_t;

  // Magnitude of a signed literal
  function automatic logic [LitW-1:0] lit_mag(input logic [LitW-1:0] lit);
    return lit[LitW-1] ? LitW'(~lit + 1'b1) : lit;
  endfunction

  // Saturating weight add
  function automatic logic [WeightW-1:0] sat_add(input logic [WeightW-1:0] a,
                                                 input logic [WeightW-1:0] b);
    logic [SumW-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW-1] ? {WeightW{1'b1}} : s[WeightW-1:0];
  endfunction

endpackage
`default_nettype wire

### design/sbls_ram.sv
`default_nettype none
// Simple dual-port RAM, one write and one registered read per cycle.
module sbls_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire logic [Width-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AddrW-1:0] rd_addr,
  output logic      [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### design/sat_branch_literal_selector.sv
`default_nettype none
// Channel | Dir | Fields (low bit first)
// in_     | in  | tuser: func; tdata: clause_literal, var_number, is_assigned; tlast: last_of_clause
// out_    | out | tdata: chosen_literal; tuser: none_found
//
// Clause literal: taken while idle; a clause end starts a weight-RAM update pass, one update per distinct variable.
// Assignment: a read then a write of the weight RAM entry.
// Select: one RAM entry scanned per cycle over all MaxVars entries, plus a wait for a free output.
// Clear and reset: a clearing pass over all MaxVars (256) entries with in_tready low.
// The output register holds a result until taken; a full output stalls only a finishing select.
module sat_branch_literal_selector import sbls_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [InDataW-1:0]  in_tdata,  // clause_literal, var_number, is_assigned
  input  wire logic [1:0]          in_tuser,  // func
  input  wire logic                in_tlast,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata, // chosen_literal
  output logic                     out_tuser  // none_found
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StClear = 3'd1;
  localparam logic [2:0] StFin   = 3'd2;
  localparam logic [2:0] StAsg   = 3'd3;
  localparam logic [2:0] StScan  = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  // Control registers
  logic [2:0]      state_r, state_nxt;
  logic [VarW-1:0] cnt_r, cnt_nxt;
  logic [FillW-1:0] fill_r, fill_nxt;
  logic [FillW-1:0] idx_r, idx_nxt;
  logic            upd_valid_r, upd_valid_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;

  // Payload registers
  logic [FillW-1:0]   len_r, len_nxt;
  logic [WeightW-1:0] gain_r, gain_nxt;
  logic [AddrW-1:0]   upd_addr_r, upd_addr_nxt;
  logic               upd_pos_r, upd_pos_nxt;
  logic               asg_val_r, asg_val_nxt;
  logic [SumW-1:0]    best_r, best_nxt;
  logic [VarW-1:0]    pick_r, pick_nxt;
  logic               pick_neg_r, pick_neg_nxt;
  logic [LitW-1:0]    out_lit_r, out_lit_nxt;
  logic               out_none_r, out_none_nxt;
  logic [LitW-1:0]    buf_r [MaxClauseLen];

  // RAM port
  logic                rd_en, wr_en;
  logic [AddrW-1:0]    rd_addr, wr_addr;
  sbls_word_t          wr_word, rd_word;
  logic [$bits(sbls_word_t)-1:0] rd_data;

  // Input field decode
  logic            in_acc;
  logic [LitW-1:0] in_lit, in_mag;
  logic [VarW-1:0] in_vnum;
  logic            in_asg;
  logic            lit_ok, buf_we;
  logic [FillW-1:0] fill_new;

  // Clause walk
  logic [LitW-1:0] cur_lit, cur_mag;
  logic            cur_seen, cur_pos;
  logic [SumW-1:0] scan_sum;

  assign in_acc  = in_tvalid && in_tready;
  assign in_lit  = in_tdata[LitW-1:0];
  assign in_vnum = in_tdata[LitW +: VarW];
  assign in_asg  = in_tdata[LitW + VarW];
  assign in_mag  = lit_mag(in_lit);
  assign lit_ok  = (in_mag != '0) && (in_mag <= LitW'(MaxVars));
  assign buf_we  = in_acc && (in_tuser == FuncLit) && lit_ok &&
                   (fill_r < FillW'(MaxClauseLen));
  assign fill_new = fill_r + FillW'(buf_we);

  assign in_tready  = (state_r == StIdle);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OutDataW - LitW){1'b0}}, out_lit_r};
  assign out_tuser  = out_none_r;

  assign rd_word = sbls_word_t'(rd_data);

  // Duplicate and polarity check of the current buffered literal
  always_comb begin
    logic [LitW-1:0] jm;
    cur_lit  = buf_r[idx_r[BufAW-1:0]];
    cur_mag  = lit_mag(cur_lit);
    cur_seen = 1'b0;
    cur_pos  = 1'b0;
    for (int j = 0; j < MaxClauseLen; j++) begin
      jm = lit_mag(buf_r[j]);
      if ((FillW'(j) < idx_r) && (jm == cur_mag)) cur_seen = 1'b1;
      if ((FillW'(j) < len_r) && !buf_r[j][LitW-1] && (jm == cur_mag)) cur_pos = 1'b1;
    end
  end

  assign scan_sum = {1'b0, rd_word.pos} + {1'b0, rd_word.neg};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    upd_valid_nxt  = 1'b0;
    len_nxt        = len_r;
    gain_nxt       = gain_r;
    upd_addr_nxt   = upd_addr_r;
    upd_pos_nxt    = upd_pos_r;
    asg_val_nxt    = asg_val_r;
    best_nxt       = best_r;
    pick_nxt       = pick_r;
    pick_neg_nxt   = pick_neg_r;
    out_lit_nxt    = out_lit_r;
    out_none_nxt   = out_none_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_word        = rd_word;

    case (state_r)
      StClear: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[AddrW-1:0];
        wr_word = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == VarW'(MaxVars - 1)) state_nxt = StIdle;
      end

      StIdle: begin
        if (in_acc) begin
          case (in_tuser)
            FuncClear: begin
              fill_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = StClear;
            end
            FuncLit: begin
              fill_nxt = fill_new;
              if (in_tlast) begin
                fill_nxt = '0;
                if (fill_new != '0) begin
                  len_nxt   = fill_new;
                  gain_nxt  = WeightW'(1) << (FillW'(MaxClauseLen) - fill_new);
                  idx_nxt   = '0;
                  state_nxt = StFin;
                end
              end
            end
            FuncAssign: begin
              if ((in_vnum != '0) && (in_vnum <= VarW'(MaxVars))) begin
                rd_en        = 1'b1;
                rd_addr      = AddrW'(in_vnum - 1'b1);
                upd_addr_nxt = AddrW'(in_vnum - 1'b1);
                asg_val_nxt  = in_asg;
                state_nxt    = StAsg;
              end
            end
            FuncSelect: begin
              cnt_nxt      = '0;
              best_nxt     = '0;
              pick_nxt     = '0;
              pick_neg_nxt = 1'b0;
              state_nxt    = StScan;
            end
            default: ;
          endcase
        end
      end

      StFin: begin
        // Issue: read the entry of the next distinct variable
        if (idx_r < len_r) begin
          idx_nxt = idx_r + 1'b1;
          if (!cur_seen) begin
            rd_en         = 1'b1;
            rd_addr       = AddrW'(cur_mag - 1'b1);
            upd_valid_nxt = 1'b1;
            upd_addr_nxt  = AddrW'(cur_mag - 1'b1);
            upd_pos_nxt   = cur_pos;
          end
        end else if (!upd_valid_r) begin
          state_nxt = StIdle;
        end
        // Write back: repeated variables are skipped at issue, so no overlap
        if (upd_valid_r) begin
          wr_en   = 1'b1;
          wr_addr = upd_addr_r;
          if (upd_pos_r) wr_word.pos = sat_add(rd_word.pos, gain_r);
          else           wr_word.neg = sat_add(rd_word.neg, gain_r);
        end
      end

      StAsg: begin
        wr_en       = 1'b1;
        wr_addr     = upd_addr_r;
        wr_word.asg = asg_val_r;
        state_nxt   = StIdle;
      end

      StScan: begin
        if (cnt_r != VarW'(MaxVars)) begin
          rd_en         = 1'b1;
          rd_addr       = cnt_r[AddrW-1:0];
          cnt_nxt       = cnt_r + 1'b1;
          upd_valid_nxt = 1'b1;
          upd_addr_nxt  = cnt_r[AddrW-1:0];
        end else if (!upd_valid_r) begin
          state_nxt = StEmit;
        end
        // Compare against the running best, strictly larger wins
        if (upd_valid_r && !rd_word.asg && (scan_sum > best_r)) begin
          best_nxt     = scan_sum;
          pick_nxt     = VarW'(upd_addr_r) + 1'b1;
          pick_neg_nxt = (rd_word.pos < rd_word.neg);
        end
      end

      StEmit: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_none_nxt   = (pick_r == '0);
          out_lit_nxt    = pick_neg_r ? LitW'(~LitW'(pick_r) + 1'b1) : LitW'(pick_r);
          state_nxt      = StIdle;
        end
      end

      default: state_nxt = StIdle;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= StClear;
      cnt_r        <= '0;
      fill_r       <= '0;
      idx_r        <= '0;
      upd_valid_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      fill_r       <= fill_nxt;
      idx_r        <= idx_nxt;
      upd_valid_r  <= upd_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    gain_r     <= gain_nxt;
    upd_addr_r <= upd_addr_nxt;
    upd_pos_r  <= upd_pos_nxt;
    asg_val_r  <= asg_val_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    pick_neg_r <= pick_neg_nxt;
    out_lit_r  <= out_lit_nxt;
    out_none_r <= out_none_nxt;
  end

  // Clause buffer
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[fill_r[BufAW-1:0]] <= in_lit;
    end
  end

  // Weight and assignment store
  sbls_ram #(
    .Width($bits(sbls_word_t)),
    .Depth(MaxVars)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

### design/sbls_checker.sv
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the selector.
module sbls_checker import sbls_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_tvalid,
  input wire logic                in_tready,
  input wire logic [1:0]          in_tuser,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata,
  input wire logic                out_tuser
);

  // A stalled result stays put
  `SBLS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // none_found matches a zero literal
  `SBLS_ASSERT_IMPL(a_none_zero, out_tvalid, out_tuser == (out_tdata[LitW-1:0] == '0))

  // Chosen literal lies within the variable range
  `SBLS_ASSERT_IMPL(a_lit_range, out_tvalid,
    (out_tdata[LitW-1:0] <= LitW'(MaxVars)) || (out_tdata[LitW-1:0] >= LitW'(-MaxVars)))

  // A select or clear transfer makes the block busy next cycle
  `SBLS_ASSERT_NEXT(a_busy_after,
    in_tvalid && in_tready && (in_tuser == FuncSelect || in_tuser == FuncClear), !in_tready)

endmodule

bind sat_branch_literal_selector sbls_checker u_sbls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

### tb/sv/tb.sv
`default_nettype none
module tb;
  import sbls_pkg::*;

  localparam int CycleLimit  = 4_000_000;
  localparam int DrainCycles = MaxVars + 16;
  localparam logic [WeightW-1:0] WeightTop = '1;

  // Expected outcome of one select
  typedef struct packed {
    logic signed [LitW-1:0] lit;
    logic                   none;
  } pick_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;  // clause_literal, var_number, is_assigned
  logic [1:0]          in_tuser;  // func
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata; // chosen_literal
  logic                out_tuser; // none_found

  // Shadow copy of the weight store and clause buffer
  logic [WeightW-1:0]     pos_wt [0:MaxVars];
  logic [WeightW-1:0]     neg_wt [0:MaxVars];
  logic                   var_taken [0:MaxVars];
  logic signed [LitW-1:0] lits_held [0:MaxClauseLen-1];
  int                     held_count;
  pick_t                  pending_picks [$];

  int   items_sent;
  int   picks_checked;
  int   clauses_closed;
  int   fail_count;
  int   cycles;
  logic bursty;
  int   pool_base;
  int   pool_span;
  pick_t seen_pick;
  pick_t due_pick;

  sat_branch_literal_selector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d picks outstanding", cycles,
               pending_picks.size());
      $display("[sat_branch_literal_selector] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------
  function automatic int lit_var(input logic signed [LitW-1:0] lit);
    int l;
    l = lit;
    return (l < 0) ? -l : l;
  endfunction

  function automatic logic [WeightW-1:0] add_capped(input logic [WeightW-1:0] w,
                                                    input int gain);
    logic [WeightW:0] s;
    s = {1'b0, w} + (WeightW+1)'(gain);
    return s[WeightW] ? WeightTop : s[WeightW-1:0];
  endfunction

  task automatic clear_store();
    for (int v = 0; v <= MaxVars; v++) begin
      pos_wt[v]    = '0;
      neg_wt[v]    = '0;
      var_taken[v] = 1'b0;
    end
    held_count = 0;
  endtask

  // Each distinct variable gains 2^-len once; positive wins if it occurs both ways
  task automatic close_clause();
    int   gain;
    int   v;
    logic dup;
    logic positive;
    clauses_closed++;
    if (held_count > 0) begin
      gain = 1 << (MaxClauseLen - held_count);
      for (int i = 0; i < held_count; i++) begin
        v        = lit_var(lits_held[i]);
        dup      = 1'b0;
        positive = 1'b0;
        for (int j = 0; j < i; j++)
          if (lit_var(lits_held[j]) == v) dup = 1'b1;
        for (int j = 0; j < held_count; j++)
          if (lits_held[j] == v) positive = 1'b1;
        if (!dup) begin
          if (positive) pos_wt[v] = add_capped(pos_wt[v], gain);
          else neg_wt[v] = add_capped(neg_wt[v], gain);
        end
      end
    end
    held_count = 0;
  endtask

  // Strictly largest pos+neg among free variables, lowest index on a tie
  function automatic pick_t best_pick();
    logic [SumW-1:0] best;
    logic [SumW-1:0] s;
    int              pick;
    pick_t           r;
    best = '0;
    pick = 0;
    for (int v = 1; v <= MaxVars; v++) begin
      if (!var_taken[v]) begin
        s = {1'b0, pos_wt[v]} + {1'b0, neg_wt[v]};
        if (s > best) begin
          best = s;
          pick = v;
        end
      end
    end
    if (pick == 0) r.lit = '0;
    else if (pos_wt[pick] >= neg_wt[pick]) r.lit = LitW'(pick);
    else r.lit = LitW'(-pick);
    r.none = (pick == 0);
    return r;
  endfunction

  task automatic track_item(input logic [1:0] func, input logic signed [LitW-1:0] lit,
                            input logic last, input logic [VarW-1:0] vnum,
                            input logic asg);
    int v;
    case (func)
      FuncClear: clear_store();
      FuncLit: begin
        v = lit_var(lit);
        if (v >= 1 && v <= MaxVars && held_count < MaxClauseLen) begin
          lits_held[held_count] = lit;
          held_count++;
        end
        if (last) close_clause();
      end
      FuncAssign: begin
        if (vnum >= 1 && vnum <= MaxVars) var_taken[vnum] = asg;
      end
      default: pending_picks.push_back(best_pick());
    endcase
  endtask

  // ---------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------
  task automatic send_item(input logic [1:0] func, input logic signed [LitW-1:0] lit,
                           input logic last, input logic [VarW-1:0] vnum,
                           input logic asg);
    @(negedge clk);
    if (bursty && $urandom_range(0, 7) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tuser  = func;
    in_tlast  = last;
    in_tdata  = InDataW'({asg, vnum, lit});
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_item(func, lit, last, vnum, asg);
    items_sent++;
  endtask

  // Unused fields of each kind carry random values
  task automatic send_lit(input logic signed [LitW-1:0] lit, input logic last);
    send_item(FuncLit, lit, last, VarW'($urandom), 1'($urandom));
  endtask

  task automatic send_assign(input logic [VarW-1:0] vnum, input logic asg);
    send_item(FuncAssign, LitW'($urandom), 1'($urandom), vnum, asg);
  endtask

  task automatic send_select();
    send_item(FuncSelect, LitW'($urandom), 1'($urandom), VarW'($urandom), 1'($urandom));
  endtask

  task automatic send_clear();
    send_item(FuncClear, LitW'($urandom), 1'($urandom), VarW'($urandom), 1'($urandom));
  endtask

  // Drop valid and hold off until every pick has come back
  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------
  // Output side: stall bursts and checking
  // ---------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (bursty && $urandom_range(0, 9) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  task automatic report_bad(input string what, input pick_t want, input pick_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch (%s) at cycle %0d: expected lit %0d none %0b, got lit %0d none %0b",
               what, cycles, $signed(want.lit), want.none, $signed(got.lit), got.none);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_pick.lit  = out_tdata[LitW-1:0];
      seen_pick.none = out_tuser;
      picks_checked++;
      if (pending_picks.size() == 0) begin
        report_bad("no pick pending", '0, seen_pick);
      end else begin
        due_pick = pending_picks.pop_front();
        if (seen_pick.lit !== due_pick.lit) report_bad("chosen_literal", due_pick, seen_pick);
        else if (seen_pick.none !== due_pick.none) report_bad("none_found", due_pick, seen_pick);
      end
    end
  end

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------

  // Empty store, single literal, bad literals, empty and repeated-variable clauses
  task automatic test_clause_rules();
    send_select();
    send_lit(10'sd256, 1'b1);
    send_lit(-10'sd1, 1'b0);
    send_lit(10'sd0, 1'b0);
    send_lit(10'sd257, 1'b0);
    send_lit(10'h200, 1'b0);
    send_lit(10'sd511, 1'b0);
    send_lit(-10'sd257, 1'b0);
    send_lit(10'sd1, 1'b1);
    send_lit(10'sd0, 1'b1);
    send_lit(-10'sd2, 1'b0);
    send_lit(-10'sd2, 1'b1);
    send_select();
  endtask

  // Assigned variables drop out of the scan; out-of-range numbers are ignored
  task automatic test_assignment_mask();
    send_assign(9'd256, 1'b1);
    send_assign(9'd0, 1'b1);
    send_assign(9'd257, 1'b1);
    send_assign(9'h1FF, 1'b1);
    send_select();
    send_assign(9'd1, 1'b1);
    send_assign(9'd2, 1'b1);
    send_select();
    send_assign(9'd256, 1'b0);
    send_select();
  endtask

  // Equal weights pick the positive literal; clear wipes everything
  task automatic test_tie_and_clear();
    send_lit(10'sd3, 1'b1);
    send_lit(-10'sd3, 1'b1);
    send_select();
    send_clear();
    send_select();
  endtask

  // Drive one positive weight into the cap, then check the 27-bit sum compare
  task automatic test_saturation();
    send_clear();
    repeat (3) send_lit(10'sd6, 1'b1);
    for (int k = 0; k < 2049; k++) begin
      send_lit(10'sd7, 1'b1);
      if (k % 512 == 511) send_select();
    end
    repeat (2) send_lit(-10'sd7, 1'b1);
    send_select();
  endtask

  // Mostly well-formed clauses over a sliding variable window, with noise
  task automatic test_random_mix(input int n);
    int                     stop;
    int                     r;
    int                     r2;
    int                     len;
    int                     v;
    logic signed [LitW-1:0] lit;
    logic [VarW-1:0]        vnum;
    stop = items_sent + n;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        pool_base = $urandom_range(1, MaxVars);
        pool_span = $urandom_range(2, 40);
      end else if (r < 55) begin
        r2 = $urandom_range(0, 49);
        if (r2 == 0) len = $urandom_range(MaxClauseLen + 1, MaxClauseLen + 4);
        else if (r2 < 5) len = $urandom_range(9, MaxClauseLen);
        else len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          r2 = $urandom_range(0, 99);
          if (r2 < 93) begin
            v = pool_base + $urandom_range(0, pool_span);
            if (v > MaxVars) v = v - MaxVars;
            lit = $urandom_range(0, 1) ? LitW'(v) : LitW'(-v);
          end else if (r2 < 97) begin
            lit = LitW'($urandom_range(0, 1023));
          end else begin
            // zero, or a magnitude past the last variable
            lit = $urandom_range(0, 1) ? 10'sd0 : LitW'($urandom_range(257, 767));
          end
          if ($urandom_range(0, 39) == 0) send_select();
          send_lit(lit, k == len - 1);
        end
      end else if (r < 75) begin
        if ($urandom_range(0, 6) == 0) begin
          vnum = VarW'($urandom);
        end else begin
          v = pool_base + $urandom_range(0, pool_span);
          if (v > MaxVars) v = v - MaxVars;
          vnum = VarW'(v);
        end
        send_assign(vnum, $urandom_range(0, 99) < 35);
      end else if (r < 97) begin
        send_select();
      end else if ($urandom_range(0, 2) == 0) begin
        send_clear();
      end
    end
  endtask

  // ---------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------
  initial begin
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = FuncClear;
    in_tlast       = 1'b0;
    rst_n          = 1'b0;
    bursty         = 1'b1;
    pool_base      = 1;
    pool_span      = 16;
    items_sent     = 0;
    picks_checked  = 0;
    clauses_closed = 0;
    fail_count     = 0;
    cycles         = 0;
    clear_store();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_clause_rules();
    test_assignment_mask();
    test_tie_and_clear();
    test_saturation();
    test_random_mix(100);
    wait_all_results();
    test_random_mix(80);
    bursty = 1'b0;
    test_random_mix(80);

    wait_all_results();
    repeat (DrainCycles) @(posedge clk);
    fail_count += pending_picks.size();

    $display("covered %0d transfers in: %0d clauses closed, %0d picks checked",
             items_sent, clauses_closed, picks_checked);
    $display("incl. bad literals, overlong clauses, weight cap, assignment masks, clears");
    if (fail_count == 0) begin
      $display("[sat_branch_literal_selector] OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("[sat_branch_literal_selector] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
